// ===== sv/assert_macros.svh =====
// Assertion helpers, included by the cook timer controller unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

// ===== sv/ctc_pkg.sv =====
package ctc_pkg;

	// Default largest cook time in seconds.
	localparam int unsigned MAX_SECONDS_DEF = 5999;

	// Register reset values.
	localparam logic [9:0] TPS_RESET = 10'd100;
	localparam logic [3:0] FT_RESET = 4'd6;

	// Register indexes, taken from paddr bit 2.
	localparam logic REG_TPS = 1'b0;
	localparam logic REG_FT  = 1'b1;

	// Minutes and seconds split.
	localparam int unsigned SEC_PER_MIN = 60;
	localparam logic [5:0] SEC_LAST = 6'd59;

	// Reciprocal of 60 scaled by 2^19; exact for every 13-bit value.
	localparam logic [13:0] DIV60_MUL = 14'd8739;
	localparam int unsigned DIV60_SHIFT = 19;

	// Command codes.
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	// Controller phase, also the phase output code.
	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_COOK   = 3'd1,
		PH_WAIT   = 3'd2,
		PH_PAUSE  = 3'd3,
		PH_FINISH = 3'd4
	} ctc_mode_t;

	// Button and door levels of one word.
	typedef struct packed {
		logic stop;
		logic start;
		logic door;
	} ctc_btn_t;

	// Drive levels and event flags of one result word.
	typedef struct packed {
		logic lamp;
		logic buzzer;
		logic done;
		logic cancel;
	} ctc_flag_t;

endpackage

// ===== sv/ctc_cvt.sv =====
// Saturates the cook time and splits it into minutes and seconds.
module ctc_cvt
	import ctc_pkg::*;
#(
	parameter int unsigned MAX_SECONDS = MAX_SECONDS_DEF
) (
	input  logic [12:0]                                      cook_seconds,
	output logic [$clog2(MAX_SECONDS / SEC_PER_MIN + 2)-1:0] minutes,
	output logic [5:0]                                       seconds
);

	localparam int MIN_W = $clog2(MAX_SECONDS / SEC_PER_MIN + 2);

	logic [12:0] sat;
	logic [26:0] prod;
	logic [7:0]  quot;
	logic [12:0] rem;

	// Clamp to the largest cook time.
	assign sat = (cook_seconds > 13'(MAX_SECONDS)) ? 13'(MAX_SECONDS) : cook_seconds;

	// Divide by 60 through a reciprocal multiply, then take the remainder.
	assign prod    = 27'(sat) * 27'(DIV60_MUL);
	assign quot    = prod[26:DIV60_SHIFT];
	assign rem     = sat - 13'(quot) * 13'(SEC_PER_MIN);
	assign minutes = MIN_W'(quot);
	assign seconds = rem[5:0];

endmodule

// ===== sv/ctc_core.sv =====
// Controller state and its next-state logic, one word per enabled cycle.
module ctc_core
	import ctc_pkg::*;
#(
	parameter int unsigned MAX_SECONDS = MAX_SECONDS_DEF
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             en,
	input  logic                                             command,
	input  logic [$clog2(MAX_SECONDS / SEC_PER_MIN + 2)-1:0] in_min,
	input  logic [5:0]                                       in_sec,
	input  ctc_btn_t                                         btn,
	input  logic [9:0]                                       tps,
	input  logic [3:0]                                       ftog,
	output ctc_mode_t                                        mode_d,
	output ctc_flag_t                                        flag_d,
	output logic [$clog2(MAX_SECONDS / SEC_PER_MIN + 2)-1:0] min_d,
	output logic [5:0]                                       sec_d
);

	localparam int MIN_W = $clog2(MAX_SECONDS / SEC_PER_MIN + 2);

	ctc_mode_t        mode_q;
	logic [9:0]       tick_q, tick_d;
	logic [MIN_W-1:0] min_q;
	logic [5:0]       sec_q;
	logic [3:0]       tog_q, tog_d;
	logic             lamp_q, buz_q;
	logic [9:0]       pause_q, pause_d;

	logic [9:0]       tick_inc;
	logic             tick_wrap;
	logic [MIN_W-1:0] dec_min;
	logic [5:0]       dec_sec;
	logic             dec_zero;
	logic             do_cook;
	logic             in_pause;
	logic             from_wait;
	logic [9:0]       pause_inc;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= PH_IDLE;
			tick_q  <= '0;
			min_q   <= '0;
			sec_q   <= '0;
			tog_q   <= '0;
			lamp_q  <= 1'b0;
			buz_q   <= 1'b0;
			pause_q <= '0;
		end else if (en) begin
			mode_q  <= mode_d;
			tick_q  <= tick_d;
			min_q   <= min_d;
			sec_q   <= sec_d;
			tog_q   <= tog_d;
			lamp_q  <= flag_d.lamp;
			buz_q   <= flag_d.buzzer;
			pause_q <= pause_d;
		end
	end

	// Shared tick counter step and the one-second countdown step.
	assign tick_inc  = tick_q + 10'd1;
	assign tick_wrap = (tick_inc >= tps);
	assign dec_zero  = (min_q == '0) && (sec_q <= 6'd1);

	always_comb begin
		dec_min = min_q;
		dec_sec = sec_q;
		if (sec_q != '0) begin
			dec_sec = sec_q - 6'd1;
		end else if (min_q != '0) begin
			dec_min = min_q - MIN_W'(1);
			dec_sec = SEC_LAST;
		end
	end

	// Next state and result flags.
	always_comb begin
		mode_d        = mode_q;
		tick_d        = tick_q;
		min_d         = min_q;
		sec_d         = sec_q;
		tog_d         = tog_q;
		flag_d.lamp   = lamp_q;
		flag_d.buzzer = buz_q;
		flag_d.done   = 1'b0;
		flag_d.cancel = 1'b0;
		pause_d       = pause_q;
		pause_inc     = '0;
		do_cook       = 1'b0;
		in_pause      = 1'b0;
		from_wait     = 1'b0;

		if (command == CMD_START) begin
			// A start word loads the time and enters cooking or finishing, and only when idle.
			if (mode_q == PH_IDLE) begin
				min_d  = in_min;
				sec_d  = in_sec;
				tick_d = '0;
				if ((in_min == '0) && (in_sec == '0)) begin
					mode_d        = PH_FINISH;
					tog_d         = 4'd1;
					flag_d.lamp   = 1'b0;
					flag_d.buzzer = 1'b0;
					flag_d.done   = 1'b1;
				end else begin
					mode_d      = PH_COOK;
					flag_d.lamp = 1'b1;
				end
			end
		end else begin
			unique case (mode_q)
				PH_COOK: begin
					if (btn.stop || !btn.door) begin
						mode_d    = PH_WAIT;
						in_pause  = !btn.stop;
						from_wait = !btn.stop;
					end else begin
						do_cook = 1'b1;
					end
				end
				PH_WAIT: begin
					in_pause  = !btn.stop;
					from_wait = !btn.stop;
				end
				PH_PAUSE: begin
					in_pause = 1'b1;
				end
				PH_FINISH: begin
					if (tick_wrap) begin
						tick_d = '0;
						if (tog_q >= ftog) begin
							flag_d.lamp   = 1'b0;
							flag_d.buzzer = 1'b0;
							tog_d         = '0;
							mode_d        = PH_IDLE;
						end else begin
							flag_d.lamp   = !lamp_q;
							flag_d.buzzer = !buz_q;
							tog_d         = tog_q + 4'd1;
						end
					end else begin
						tick_d = tick_inc;
					end
				end
				default: begin
					mode_d = PH_IDLE;
				end
			endcase

			// Pause blink counter restarts when the pause is entered from cooking or the wait phase.
			pause_inc = (from_wait ? 10'd0 : pause_q) + 10'd1;

			// Paused: resume, cancel or blink.
			if (in_pause) begin
				priority if (btn.start && btn.door) begin
					mode_d      = PH_COOK;
					flag_d.lamp = 1'b1;
					do_cook     = 1'b1;
					if (from_wait) begin
						pause_d = '0;
					end
				end else if (btn.stop) begin
					mode_d        = PH_IDLE;
					flag_d.lamp   = 1'b0;
					min_d         = '0;
					sec_d         = '0;
					tick_d        = '0;
					pause_d       = '0;
					flag_d.cancel = 1'b1;
				end else begin
					mode_d = PH_PAUSE;
					if (pause_inc >= tps) begin
						pause_d     = '0;
						flag_d.lamp = !lamp_q;
					end else begin
						pause_d = pause_inc;
					end
				end
			end

			// One cooking tick, ending the countdown when it reaches zero.
			if (do_cook) begin
				if (tick_wrap) begin
					tick_d = '0;
					min_d  = dec_min;
					sec_d  = dec_sec;
					if (dec_zero) begin
						mode_d        = PH_FINISH;
						min_d         = '0;
						sec_d         = '0;
						tog_d         = 4'd1;
						flag_d.lamp   = 1'b0;
						flag_d.buzzer = 1'b0;
						flag_d.done   = 1'b1;
					end
				end else begin
					tick_d = tick_inc;
				end
			end
		end
	end

endmodule

// ===== sv/cook_timer_controller_unit.sv =====
// Cook timer controller.
// Input channel (in_valid/in_stall): each word is a 10 ms tick (command 0)
// or a start command (command 1) with cook_seconds; the button and door
// levels ride along with every word. Output channel (out_valid/out_stall):
// exactly one result word per input word, in order, with phase, lamp and
// buzzer levels, remaining time as minutes and seconds, and event pulses.
// A word accepted on the input channel lands in the input register; once the
// output register is free or being drained, it updates the controller state
// and loads the output register. Throughput is one word per cycle while
// out_stall allows, set by the single state update between the two registers.
// When out_stall holds a pending result, the input register keeps its word
// and in_stall rises in the same cycle; no word is lost or dropped.
// The APB port sets ticks_per_second (address 0) and finish_toggles
// (address 4); write them only while no word is in flight.
// Reset (arst_n low) returns the controller to idle with the lamp and
// buzzer off, clears the pipeline valids and restores the register defaults.
module cook_timer_controller_unit
	import ctc_pkg::*;
#(
	parameter int unsigned MAX_SECONDS = MAX_SECONDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [12:0] cook_seconds,
	input  logic        stop_pressed,
	input  logic        start_pressed,
	input  logic        door_closed,
	// Output channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  phase,
	output logic        lamp_on,
	output logic        buzzer_on,
	output logic [6:0]  show_minutes,
	output logic [5:0]  show_seconds,
	output logic        done_pulse,
	output logic        cancel_pulse,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	`include "assert_macros.svh"

	localparam int MIN_W = $clog2(MAX_SECONDS / SEC_PER_MIN + 2);

	logic [9:0]       tps_q;
	logic [3:0]       ft_q;

	logic [MIN_W-1:0] cvt_min;
	logic [5:0]       cvt_sec;

	logic             valid_s1;
	logic             cmd_s1;
	logic [MIN_W-1:0] min_s1;
	logic [5:0]       sec_s1;
	ctc_btn_t         btn_s1;

	logic             adv;
	ctc_mode_t        mode_d;
	ctc_flag_t        flag_d;
	logic [MIN_W-1:0] min_d;
	logic [5:0]       sec_d;

	logic             out_valid_q;
	ctc_mode_t        mode_q;
	ctc_flag_t        flag_q;
	logic [MIN_W-1:0] min_q;
	logic [5:0]       sec_q;

	// Configuration registers.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
			ft_q  <= FT_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_TPS: tps_q <= pwdata[9:0];
				REG_FT:  ft_q  <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_TPS: prdata = {22'd0, tps_q};
			REG_FT:  prdata = {28'd0, ft_q};
			default: prdata = '0;
		endcase
	end

	// Split the incoming cook time before it is registered.
	ctc_cvt #(
		.MAX_SECONDS(MAX_SECONDS)
	) u_cvt (
		.cook_seconds(cook_seconds),
		.minutes     (cvt_min),
		.seconds     (cvt_sec)
	);

	// Pipeline advances whenever the output register is free or being drained.
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1       <= command;
			min_s1       <= cvt_min;
			sec_s1       <= cvt_sec;
			btn_s1.stop  <= stop_pressed;
			btn_s1.start <= start_pressed;
			btn_s1.door  <= door_closed;
		end
	end

	// Controller state update.
	ctc_core #(
		.MAX_SECONDS(MAX_SECONDS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (valid_s1 && adv),
		.command(cmd_s1),
		.in_min (min_s1),
		.in_sec (sec_s1),
		.btn    (btn_s1),
		.tps    (tps_q),
		.ftog   (ft_q),
		.mode_d (mode_d),
		.flag_d (flag_d),
		.min_d  (min_d),
		.sec_d  (sec_d)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			mode_q <= mode_d;
			flag_q <= flag_d;
			min_q  <= min_d;
			sec_q  <= sec_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign phase        = mode_q;
	assign lamp_on      = flag_q.lamp;
	assign buzzer_on    = flag_q.buzzer;
	assign show_minutes = 7'(min_q);
	assign show_seconds = sec_q;
	assign done_pulse   = flag_q.done;
	assign cancel_pulse = flag_q.cancel;

	// Checks on the controller results.
	`ASSERT_NEVER(a_one_event, clk, arst_n, out_valid && done_pulse && cancel_pulse, "done and cancel together")
	`ASSERT_IMPLY(a_zero_time, clk, arst_n, out_valid && (phase == PH_IDLE || phase == PH_FINISH), show_minutes == 7'd0 && show_seconds == 6'd0, "time shown while idle or finishing")
	`ASSERT_IMPLY(a_buzzer_phase, clk, arst_n, out_valid && buzzer_on, phase == PH_FINISH, "buzzer outside finishing")
	`ASSERT_IMPLY(a_stall_src, clk, arst_n, in_stall, valid_s1 && out_valid_q, "input stalled with a free pipeline")

endmodule

// ===== sim/cook_timer_monitor.sv =====
// Watches both channels and the APB port of the cook timer controller,
// predicts one result word per accepted input word and compares them in order.
module cook_timer_monitor
	import ctc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        command,
	input  logic [12:0] cook_seconds,
	input  logic        stop_pressed,
	input  logic        start_pressed,
	input  logic        door_closed,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  phase,
	input  logic        lamp_on,
	input  logic        buzzer_on,
	input  logic [6:0]  show_minutes,
	input  logic [5:0]  show_seconds,
	input  logic        done_pulse,
	input  logic        cancel_pulse,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);

	localparam logic [12:0] SECONDS_CAP = 13'(MAX_SECONDS_DEF);
	localparam int PRINT_LIMIT = 100;

	// One result word as the display and drivers show it.
	typedef struct packed {
		logic [2:0] phase;
		logic       lamp;
		logic       buzzer;
		logic [6:0] minutes;
		logic [5:0] seconds;
		logic       done;
		logic       cancel;
	} timer_view_t;

	timer_view_t awaited_views[$];

	// Register copies.
	logic [9:0] tps;
	logic [3:0] ftog;

	// Controller state copy.
	ctc_mode_t  mode;
	logic [9:0] tick_cnt;
	logic [12:0] remain;
	logic [3:0] toggles;
	logic       lamp;
	logic       buzzer;
	logic [9:0] blink_cnt;

	initial fail_count = 0;

	task automatic report_mismatch(input string what, input int got, input int want);
		if (fail_count < PRINT_LIMIT)
			$display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
		fail_count++;
	endtask

	// The countdown has run out: start the lamp and buzzer toggling.
	task automatic enter_finishing();
		mode = PH_FINISH;
		remain = '0;
		tick_cnt = '0;
		toggles = 4'd1;
		lamp = 1'b0;
		buzzer = 1'b0;
	endtask

	// One counted tick of cooking; a full period takes one second off.
	task automatic count_cook_tick(output logic reached_zero);
		reached_zero = 1'b0;
		tick_cnt = tick_cnt + 10'd1;
		if (tick_cnt >= tps) begin
			tick_cnt = '0;
			if (remain != '0)
				remain = remain - 13'd1;
			if (remain == '0) begin
				enter_finishing();
				reached_zero = 1'b1;
			end
		end
	endtask

	// Advances the controller copy by one input word and gives its result.
	task automatic step_timer(input logic cmd, input logic [12:0] secs, input logic stop,
			input logic start, input logic door, output timer_view_t view);
		logic done;
		logic cancel;
		logic evaluate;
		done = 1'b0;
		cancel = 1'b0;
		evaluate = 1'b0;
		if (cmd == CMD_START) begin
			// A start is only taken in idle, and it does no tick work.
			if (mode == PH_IDLE) begin
				remain = (secs > SECONDS_CAP) ? SECONDS_CAP : secs;
				tick_cnt = '0;
				if (remain == '0) begin
					enter_finishing();
					done = 1'b1;
				end else begin
					mode = PH_COOK;
					lamp = 1'b1;
				end
			end
		end else begin
			case (mode)
				PH_COOK: begin
					if (stop || !door)
						mode = PH_WAIT;
					else
						count_cook_tick(done);
				end
				PH_WAIT, PH_PAUSE: begin
				end
				PH_FINISH: begin
					tick_cnt = tick_cnt + 10'd1;
					if (tick_cnt >= tps) begin
						tick_cnt = '0;
						if (toggles >= ftog) begin
							lamp = 1'b0;
							buzzer = 1'b0;
							toggles = '0;
							mode = PH_IDLE;
						end else begin
							lamp = ~lamp;
							buzzer = ~buzzer;
							toggles = toggles + 4'd1;
						end
					end
				end
				default: begin
					mode = PH_IDLE;
				end
			endcase

			// Released stop starts the pause on the same word.
			if (mode == PH_WAIT && !stop) begin
				mode = PH_PAUSE;
				blink_cnt = '0;
				evaluate = 1'b1;
			end else if (mode == PH_PAUSE) begin
				evaluate = 1'b1;
			end

			// Paused: resume, cancel or blink the lamp.
			if (evaluate) begin
				if (start && door) begin
					mode = PH_COOK;
					lamp = 1'b1;
					count_cook_tick(done);
				end else if (stop) begin
					mode = PH_IDLE;
					lamp = 1'b0;
					remain = '0;
					tick_cnt = '0;
					blink_cnt = '0;
					cancel = 1'b1;
				end else begin
					blink_cnt = blink_cnt + 10'd1;
					if (blink_cnt >= tps) begin
						blink_cnt = '0;
						lamp = ~lamp;
					end
				end
			end
		end
		view.phase = mode;
		view.lamp = lamp;
		view.buzzer = buzzer;
		view.minutes = 7'(remain / SEC_PER_MIN);
		view.seconds = 6'(remain % SEC_PER_MIN);
		view.done = done;
		view.cancel = cancel;
	endtask

	// Track register writes, predict accepted words and check results.
	always @(posedge clk) begin
		timer_view_t want;
		timer_view_t got;
		if (!arst_n) begin
			tps = TPS_RESET;
			ftog = FT_RESET;
			mode = PH_IDLE;
			tick_cnt = '0;
			remain = '0;
			toggles = '0;
			lamp = 1'b0;
			buzzer = 1'b0;
			blink_cnt = '0;
			awaited_views.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_TPS)
					tps = pwdata[9:0];
				else
					ftog = pwdata[3:0];
			end
			if (in_valid && !in_stall) begin
				step_timer(command, cook_seconds, stop_pressed, start_pressed, door_closed,
					want);
				awaited_views.push_back(want);
			end
			if (out_valid && !out_stall) begin
				got = '{phase, lamp_on, buzzer_on, show_minutes, show_seconds, done_pulse,
					cancel_pulse};
				if (awaited_views.size() == 0) begin
					report_mismatch("unexpected result word", int'(got), 0);
				end else begin
					want = awaited_views.pop_front();
					if (got.phase !== want.phase)
						report_mismatch("phase", int'(got.phase), int'(want.phase));
					if (got.lamp !== want.lamp)
						report_mismatch("lamp_on", int'(got.lamp), int'(want.lamp));
					if (got.buzzer !== want.buzzer)
						report_mismatch("buzzer_on", int'(got.buzzer), int'(want.buzzer));
					if (got.minutes !== want.minutes)
						report_mismatch("show_minutes", int'(got.minutes),
							int'(want.minutes));
					if (got.seconds !== want.seconds)
						report_mismatch("show_seconds", int'(got.seconds),
							int'(want.seconds));
					if (got.done !== want.done)
						report_mismatch("done_pulse", int'(got.done), int'(want.done));
					if (got.cancel !== want.cancel)
						report_mismatch("cancel_pulse", int'(got.cancel), int'(want.cancel));
				end
			end
		end
		pending <= awaited_views.size();
	end

endmodule

// ===== sim/cook_timer_controller_unit_test.sv =====
// Stimulus and verdict for the cook timer controller.
module cook_timer_controller_unit_test;
	import ctc_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TARGET_WORDS = 1750;
	localparam int SETTING_COUNT = 8;
	localparam int TAIL_CYCLES = 4;
	localparam int GAP_PERCENT = 16;
	localparam logic [2:0] ADDR_TPS = 3'd0;
	localparam logic [2:0] ADDR_FT = 3'd4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        command = CMD_TICK;
	logic [12:0] cook_seconds = '0;
	logic        stop_pressed = 1'b0;
	logic        start_pressed = 1'b0;
	logic        door_closed = 1'b1;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  phase;
	logic        lamp_on;
	logic        buzzer_on;
	logic [6:0]  show_minutes;
	logic [5:0]  show_seconds;
	logic        done_pulse;
	logic        cancel_pulse;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;

	bit gaps_on = 1'b1;
	bit hold_req = 1'b0;
	int words_sent = 0;
	int quiet_cycles = 0;
	int cur_tps = int'(TPS_RESET);
	int cur_ft = int'(FT_RESET);

	always #2 clk = ~clk;

	cook_timer_controller_unit uut (.*);
	cook_timer_monitor monitor (.*);

	// Give up when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side: random stalls, or one long hold-off on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_stall <= gaps_on && ($urandom_range(99) < GAP_PERCENT);
			end
		end
	end

	// Offers one word, with random idle cycles first, and waits for acceptance.
	task automatic send_word(input logic cmd, input logic [12:0] secs, input logic stop,
			input logic start, input logic door);
		while (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		cook_seconds <= secs;
		stop_pressed <= stop;
		start_pressed <= start;
		door_closed <= door;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic tick(input logic stop, input logic start, input logic door);
		send_word(CMD_TICK, 13'($urandom_range(8191)), stop, start, door);
	endtask

	// Stops offering and waits until every predicted word has come back.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input int tps, input int ft);
		drain();
		write_reg(ADDR_TPS, tps);
		write_reg(ADDR_FT, ft);
		cur_tps = tps;
		cur_ft = ft;
	endtask

	// Pause by stop or by the door, a few paused ticks, then resume or cancel.
	task automatic pause_episode();
		if ($urandom_range(1)) begin
			repeat ($urandom_range(1, 3))
				tick(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
			tick(1'b0, 1'b0, 1'b1);
		end else begin
			tick(1'b0, 1'b0, 1'b0);
		end
		repeat ($urandom_range(0, 3))
			tick(1'b0, 1'b0, 1'($urandom_range(1)));
		if ($urandom_range(9) < 7)
			tick(1'($urandom_range(1)), 1'b1, 1'b1);
		else
			tick(1'b1, 1'b0, 1'($urandom_range(1)));
	endtask

	// One cook from start to finish, with pauses and noise along the way.
	task automatic run_cook_session();
		int tps_eff;
		int ft_eff;
		int secs;
		int len;
		int roll;
		tps_eff = (cur_tps == 0) ? 1 : cur_tps;
		ft_eff = (cur_ft == 0) ? 1 : cur_ft;
		roll = $urandom_range(99);
		if (tps_eff > 12 || (roll >= 8 && roll < 15)) begin
			// Random cook times usually do not finish here; the closing stop cancels any still running.
			secs = $urandom_range(8191);
			len = $urandom_range(4, 30);
		end else begin
			secs = (roll < 8) ? 0 : $urandom_range(1, 4);
			len = secs * tps_eff + (ft_eff + 1) * tps_eff + 2;
		end
		send_word(CMD_START, 13'(secs), 1'($urandom_range(1)), 1'($urandom_range(1)),
			1'($urandom_range(1)));
		for (int k = 0; k < len; k++) begin
			roll = $urandom_range(99);
			if (roll < 88)
				tick(1'b0, $urandom_range(9) < 3, 1'b1);
			else if (roll < 96)
				pause_episode();
			else
				tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
		end
		tick(1'b1, 1'b0, 1'b1);
		tick(1'b0, 1'b0, 1'b1);
		tick(1'b1, 1'b0, 1'b1);
	endtask

	initial begin
		int tps_list[SETTING_COUNT];
		int ft_list[SETTING_COUNT];
		int first_word;
		tps_list = '{1, 2, 0, 3, 1000, 5, 1, 1023};
		ft_list = '{1, 4, 0, 15, 7, 2, 15, 6};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero time, saturation, pause by stop and door, resume, cancel.
		configure(2, 2);
		tick(1'b0, 1'b0, 1'b1);
		send_word(CMD_START, 13'd0, 1'b0, 1'b0, 1'b1);
		repeat (5) tick(1'b0, 1'b0, 1'b1);
		send_word(CMD_START, 13'h1FFF, 1'b1, 1'b1, 1'b0);
		tick(1'b0, 1'b0, 1'b1);
		send_word(CMD_START, 13'd5, 1'b0, 1'b0, 1'b1);
		tick(1'b1, 1'b0, 1'b1);
		tick(1'b1, 1'b1, 1'b1);
		tick(1'b0, 1'b0, 1'b1);
		tick(1'b0, 1'b0, 1'b1);
		tick(1'b0, 1'b1, 1'b1);
		tick(1'b0, 1'b0, 1'b0);
		tick(1'b0, 1'b1, 1'b0);
		tick(1'b1, 1'b0, 1'b1);
		send_word(CMD_START, 13'd1, 1'b0, 1'b0, 1'b0);
		tick(1'b0, 1'b0, 1'b0);
		tick(1'b1, 1'b1, 1'b1);
		tick(1'b0, 1'b0, 1'b1);
		repeat (4) tick(1'b0, 1'b0, 1'b1);
		send_word(CMD_START, 13'd5999, 1'b0, 1'b0, 1'b1);
		tick(1'b1, 1'b0, 1'b1);
		tick(1'b1, 1'b0, 1'b1);
		send_word(CMD_START, 13'd6000, 1'b0, 1'b0, 1'b1);
		tick(1'b0, 1'b0, 1'b0);
		tick(1'b1, 1'b0, 1'b1);

		// Lowering the second length while a count is past the new value.
		configure(12, 3);
		send_word(CMD_START, 13'd2, 1'b0, 1'b0, 1'b1);
		repeat (8) tick(1'b0, 1'b0, 1'b1);
		configure(3, 3);
		repeat (14) tick(1'b0, 1'b0, 1'b1);

		// Random sessions over several register settings.
		for (int s = 0; s < SETTING_COUNT; s++) begin
			configure(tps_list[s], ft_list[s]);
			hold_req = (s == 0);
			gaps_on = (s != 3);
			first_word = words_sent;
			while (words_sent - first_word < TARGET_WORDS / SETTING_COUNT) begin
				if ($urandom_range(99) < 6)
					send_word(1'($urandom_range(1)), 13'($urandom_range(8191)),
						1'($urandom_range(1)), 1'($urandom_range(1)),
						1'($urandom_range(1)));
				else
					run_cook_session();
			end
		end
		gaps_on = 1'b1;

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/ctc_pkg.sv
sv/ctc_cvt.sv
sv/ctc_core.sv
sv/cook_timer_controller_unit.sv
sim/cook_timer_monitor.sv
sim/cook_timer_controller_unit_test.sv
